// ===== rtl/assert_macros.svh =====
// Assertion macros for the datapath; clocked on clk, quiet during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// Shared types and constants for the sparse triplet transpose block.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int MAX_TERMS = 64;
  localparam int MAX_DIM   = 64;

  localparam int TAW   = $clog2(MAX_TERMS);      // term store address width
  localparam int CAW   = $clog2(MAX_DIM);        // column table address width
  localparam int IDX_W = ((TAW > CAW) ? TAW : CAW) + 1;
  localparam int CNT_W = TAW + 1;                // holds 0..MAX_TERMS
  localparam int DIM_W = 7;
  localparam int VAL_W = 32;

  // Configuration register indexes
  localparam logic CFG_SRC_ROWS = 1'b0;
  localparam logic CFG_SRC_COLS = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]        row;
    logic [DIM_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0]        out_row;
    logic [DIM_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    end_of_run;
    logic                    dropped;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0]        row;
    logic [DIM_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } term_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_sweep;
    logic cnt_wr;
    logic pre;
    logic sc_wr;
    logic emit;
    logic idx_clr;
    logic idx_inc;
    logic run_clr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic idx_last;
    logic clr_done;
    logic pre_done;
  } status_t;

endpackage

// ===== rtl/stt_ctrl.sv =====
// Sequencer for the reset clear sweep and the load, count, prefix, scatter and emit passes.
`timescale 1ns / 1ps

module stt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            last,
  input  stt_pkg::status_t st,
  output stt_pkg::cmd_t    cmd,
  output logic            busy
);
  import stt_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_START   = 11'b000_0000_0100,
    S_CNT_RD  = 11'b000_0000_1000,
    S_CNT_COL = 11'b000_0001_0000,
    S_CNT_WR  = 11'b000_0010_0000,
    S_PRE     = 11'b000_0100_0000,
    S_SC_RD   = 11'b000_1000_0000,
    S_SC_SLOT = 11'b001_0000_0000,
    S_SC_WR   = 11'b010_0000_0000,
    S_EMIT    = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_sweep = 1'b1;
        if (st.clr_done) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last) state_next = S_START;
        end
      end
      S_START: begin
        cmd.idx_clr = 1'b1;
        if (st.count_zero) begin
          cmd.run_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_CNT_RD;
        end
      end
      S_CNT_RD:  state_next = S_CNT_COL;
      S_CNT_COL: state_next = S_CNT_WR;
      S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_PRE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CNT_RD;
        end
      end
      S_PRE: begin
        cmd.pre = 1'b1;
        if (st.pre_done) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SC_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SC_RD:   state_next = S_SC_SLOT;
      S_SC_SLOT: state_next = S_SC_WR;
      S_SC_WR: begin
        cmd.sc_wr = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SC_RD;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          cmd.run_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ===== rtl/stt_datapath.sv =====
// Term, column and output stores with the index counter and result register.
`timescale 1ns / 1ps

module stt_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  stt_pkg::cmd_t              cmd,
  output stt_pkg::status_t           st,
  input  stt_pkg::item_t             item,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [stt_pkg::DIM_W-1:0]  cfg_data,
  output stt_pkg::result_t           result,
  output logic                       result_valid
);
  import stt_pkg::*;

  `include "assert_macros.svh"

  term_t            term_mem [MAX_TERMS];
  term_t            out_mem  [MAX_TERMS];
  logic [CNT_W-1:0] cnt_mem  [MAX_DIM];
  logic [TAW-1:0]   slot_mem [MAX_DIM];

  logic [DIM_W-1:0] src_cols;
  logic [CNT_W-1:0] term_count;
  logic             drop_flag;
  logic [IDX_W-1:0] idx;

  term_t            term_q;
  term_t            out_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TAW-1:0]   slot_q;

  logic             pre_pend;
  logic [CAW-1:0]   pre_addr;
  logic [CNT_W-1:0] pre_sum;
  logic             eor_pend;
  logic             drop_pend;

  logic             load_ok;
  logic [CAW-1:0]   col_addr;
  logic [CAW-1:0]   cnt_rd_addr;
  logic             cnt_we;
  logic [CAW-1:0]   cnt_wa;
  logic [CNT_W-1:0] cnt_wd;
  logic             slot_we;
  logic [CAW-1:0]   slot_wa;
  logic [TAW-1:0]   slot_wd;

  // Stored columns are 1..MAX_DIM, so col - 1 fits the column address.
  assign col_addr = CAW'(term_q.col - DIM_W'(1));

  assign load_ok = (item.col != '0) && (item.col <= src_cols) &&
                   (item.col <= DIM_W'(MAX_DIM)) && (term_count < CNT_W'(MAX_TERMS));

  assign st.count_zero = (term_count == '0);
  assign st.idx_last   = (CNT_W'(idx) + CNT_W'(1) == term_count);
  assign st.clr_done   = (idx[CAW-1:0] == CAW'(MAX_DIM - 1));
  assign st.pre_done   = (idx == IDX_W'(MAX_DIM));

  // Configuration; src_rows has no effect on the transpose, writes are taken and ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      src_cols <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_ROWS: ;
        CFG_SRC_COLS: src_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Run control
  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
      drop_flag  <= 1'b0;
      idx        <= '0;
    end else begin
      if (cmd.run_clr) begin
        term_count <= '0;
        drop_flag  <= 1'b0;
      end else if (cmd.load) begin
        if (load_ok) term_count <= term_count + CNT_W'(1);
        else         drop_flag  <= 1'b1;
      end
      if (cmd.idx_clr)      idx <= '0;
      else if (cmd.idx_inc) idx <= idx + IDX_W'(1);
    end
  end

  // Term store
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      term_mem[term_count[TAW-1:0]] <= '{row: item.row, col: item.col, value: item.value};
    end
    term_q <= term_mem[idx[TAW-1:0]];
  end

  // Column count table: cleared by the reset sweep and again during each prefix pass
  assign cnt_rd_addr = cmd.pre ? idx[CAW-1:0] : col_addr;

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = col_addr;
    cnt_wd = '0;
    if (cmd.clr_sweep) begin
      cnt_we = 1'b1;
      cnt_wa = idx[CAW-1:0];
    end else if (pre_pend) begin
      cnt_we = 1'b1;
      cnt_wa = pre_addr;
    end else if (cmd.cnt_wr) begin
      cnt_we = 1'b1;
      cnt_wd = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cnt_rd_addr];
  end

  // Prefix pass: read one count per cycle, write the running start slot in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_pend <= 1'b0;
    end else begin
      pre_pend <= cmd.pre && !st.pre_done;
    end
    pre_addr <= idx[CAW-1:0];
    if (cmd.idx_clr && !cmd.pre) pre_sum <= '0;
    else if (pre_pend)           pre_sum <= pre_sum + cnt_q;
  end

  // Next-slot table
  always_comb begin
    slot_we = 1'b0;
    slot_wa = col_addr;
    slot_wd = slot_q + TAW'(1);
    if (pre_pend) begin
      slot_we = 1'b1;
      slot_wa = pre_addr;
      slot_wd = pre_sum[TAW-1:0];
    end else if (cmd.sc_wr) begin
      slot_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_q <= slot_mem[col_addr];
  end

  // Output store: scatter with row and column swapped
  always_ff @(posedge clk) begin
    if (cmd.sc_wr) begin
      out_mem[slot_q] <= '{row: term_q.col, col: term_q.row, value: term_q.value};
    end
    out_q <= out_mem[idx[TAW-1:0]];
  end

  // Result strobe is registered from the emit command, in step with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
    eor_pend  <= st.idx_last;
    drop_pend <= drop_flag;
  end

  assign result.out_row    = out_q.row;
  assign result.out_col    = out_q.col;
  assign result.out_value  = out_q.value;
  assign result.end_of_run = eor_pend;
  assign result.dropped    = drop_pend;

  `STT_ASSERT(a_count_bound, 1'b1, term_count <= CNT_W'(MAX_TERMS), "term count overflow")
  `STT_ASSERT(a_run_cleared, result_valid && eor_pend, (term_count == '0) && !drop_flag,
              "run state not cleared at final transfer")
  `STT_ASSERT_NEXT(a_full_drop, cmd.load && (term_count == CNT_W'(MAX_TERMS)),
                   drop_flag && (term_count == CNT_W'(MAX_TERMS)), "full store did not drop")

endmodule

// ===== rtl/sparse_triplet_transpose.sv =====
// Top level of the sparse triplet transpose block.
`timescale 1ns / 1ps

// Load source terms one per cycle (start while busy is low). The term with last
// set starts the run: a check state (with no stored term the block goes back to
// idle), a count pass that reads each stored term and writes back the count of
// its column, a prefix pass over the column table, a scatter pass that reads each
// term, takes its slot and writes it to the output store, then one result per
// cycle, the first in the cycle after emission starts. The count and scatter
// passes read-modify-write the column tables. Results are strobed by result_valid
// for one cycle each and cannot be held off. After reset the block stays busy
// while it clears the column count table; configuration writes are always taken.
module sparse_triplet_transpose (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  stt_pkg::item_t            item,
  output stt_pkg::result_t          result,
  output logic                      result_valid,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [stt_pkg::DIM_W-1:0] cfg_data
);
  import stt_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  stt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (item.last),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  stt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
